/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/fbfla_pkg.sv */
// Package for the fixed-block free-list allocator: codes, defaults, and
// controller/datapath interface types. No dependencies.
package fbfla_pkg;

  localparam int BlockSizeDef      = 4096;
  localparam int BlocksPerChunkDef = 64;
  localparam int MaxChunksDef      = 16;

  localparam int StackDepth = 1024;
  localparam int IdxW       = 10;
  localparam int TopW       = 11;
  localparam int SizeW      = 24;
  localparam int AlignW     = 4;
  localparam int LimitW     = 5;
  localparam logic [LimitW-1:0] ChunkLimitRst = 5'd16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_OVERSIZED = 3'd1,
    STS_NULL      = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_OVERFLOW  = 3'd4
  } status_e;

  // What an incoming request turns into, given the current state.
  typedef enum logic [2:0] {
    CLS_OVERSIZED,
    CLS_NULL,
    CLS_EMPTY,
    CLS_OVERFLOW,
    CLS_PUSH,
    CLS_POP,
    CLS_CARVE
  } class_e;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic push;
    logic pop;
    logic carve;
    logic fill_step;
  } fbfla_cmd_t;

  typedef struct packed {
    class_e cls;
    logic   fill_last;
  } fbfla_stat_t;

endpackage

/* rtl/fbfla_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfla_ram #(
  parameter int Width = 10,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fbfla_ctrl.sv */
// Controller for the allocator: idle/fill state machine, issues commands.
// Depends on fbfla_pkg.
module fbfla_ctrl import fbfla_pkg::*; #(
  parameter int BlocksPerChunk = BlocksPerChunkDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  fbfla_stat_t stat_i,
  output fbfla_cmd_t  cmd_o,
  output logic        busy
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          case (stat_i.cls)
            CLS_PUSH: cmd_o.push = 1'b1;
            CLS_POP:  cmd_o.pop  = 1'b1;
            CLS_CARVE: begin
              cmd_o.carve = 1'b1;
              // top block is granted directly; the rest are written in FILL
              if (BlocksPerChunk > 1) begin
                state_d = S_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        busy            = 1'b1;
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/fbfla_dp.sv */
// Datapath for the allocator: stack pointer, chunk counters, request
// classification, free-stack RAM and result registers. Depends on fbfla_pkg, fbfla_ram.
module fbfla_dp import fbfla_pkg::*; #(
  parameter int BlockSize      = BlockSizeDef,
  parameter int BlocksPerChunk = BlocksPerChunkDef,
  parameter int MaxChunks      = MaxChunksDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              chunk_limit_we_i,
  input  logic [LimitW-1:0] chunk_limit_i,
  input  logic              op_i,
  input  logic [SizeW-1:0]  request_size_i,
  input  logic [AlignW-1:0] align_log2_i,
  input  logic              is_null_i,
  input  logic [IdxW-1:0]   block_index_i,
  input  fbfla_cmd_t        cmd_i,
  output fbfla_stat_t       stat_o,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [IdxW-1:0]   granted_block_o,
  output logic              refilled_o
);

  localparam int CcW      = $clog2(MaxChunks + 1);
  localparam int CmpW     = (CcW > LimitW) ? CcW : LimitW;
  localparam int FillW    = (BlocksPerChunk > 1) ? $clog2(BlocksPerChunk) : 1;
  localparam int AlignMax = $clog2(BlockSize + 1) - 1;  // floor(log2(BlockSize))

  logic [TopW-1:0]   top_q;
  logic [CcW-1:0]    chunk_cnt_q;
  logic [IdxW-1:0]   base_q;
  logic [IdxW-1:0]   fill_base_q;
  logic [FillW-1:0]  fill_cnt_q;
  logic [LimitW-1:0] chunk_limit_q;
  logic              res_valid_q;
  status_e           status_q;
  logic [IdxW-1:0]   granted_q;
  logic              refilled_q;
  logic              from_ram_q;

  logic              oversized;
  logic [CmpW-1:0]   limit_eff;
  logic              can_carve;
  class_e            cls;
  status_e           status_d;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [IdxW-1:0]   ram_wdata;
  logic [IdxW-1:0]   ram_rdata;
  logic [IdxW-1:0]   carve_grant;

  // ---- classification ----
  assign oversized = (request_size_i > SizeW'(BlockSize)) ||
                     ({1'b0, align_log2_i} > (AlignW + 1)'(AlignMax));

  always_comb begin
    if (CmpW'(chunk_limit_q) > CmpW'(MaxChunks)) begin
      limit_eff = CmpW'(MaxChunks);
    end else begin
      limit_eff = CmpW'(chunk_limit_q);
    end
  end

  assign can_carve = CmpW'(chunk_cnt_q) < limit_eff;

  always_comb begin
    if (op_i == OP_ALLOC) begin
      if (oversized) begin
        cls = CLS_OVERSIZED;
      end else if (top_q != '0) begin
        cls = CLS_POP;
      end else if (can_carve) begin
        cls = CLS_CARVE;
      end else begin
        cls = CLS_EMPTY;
      end
    end else begin
      if (is_null_i) begin
        cls = CLS_NULL;
      end else if (oversized) begin
        cls = CLS_OVERSIZED;
      end else if (top_q == TopW'(StackDepth)) begin
        cls = CLS_OVERFLOW;
      end else begin
        cls = CLS_PUSH;
      end
    end
  end

  always_comb begin
    case (cls)
      CLS_OVERSIZED: status_d = STS_OVERSIZED;
      CLS_NULL:      status_d = STS_NULL;
      CLS_EMPTY:     status_d = STS_EMPTY;
      CLS_OVERFLOW:  status_d = STS_OVERFLOW;
      default:       status_d = STS_OK;
    endcase
  end

  assign stat_o.cls       = cls;
  assign stat_o.fill_last = (fill_cnt_q == FillW'(BlocksPerChunk - 2));

  assign carve_grant = base_q + IdxW'(BlocksPerChunk - 1);

  // ---- free stack ----
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = top_q[IdxW-1:0];
    ram_wdata = block_index_i;
    if (cmd_i.push) begin
      ram_we = 1'b1;
    end else if (cmd_i.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = IdxW'(fill_cnt_q);
      ram_wdata = fill_base_q + IdxW'(fill_cnt_q);
    end
  end

  fbfla_ram #(
    .Width (IdxW),
    .Depth (StackDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pop),
    .raddr_i (IdxW'(top_q - TopW'(1))),
    .rdata_o (ram_rdata)
  );

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q         <= '0;
      chunk_cnt_q   <= '0;
      base_q        <= '0;
      fill_cnt_q    <= '0;
      chunk_limit_q <= ChunkLimitRst;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.accept;
      if (chunk_limit_we_i) begin
        chunk_limit_q <= chunk_limit_i;
      end
      if (cmd_i.push) begin
        top_q <= top_q + TopW'(1);
      end else if (cmd_i.pop) begin
        top_q <= top_q - TopW'(1);
      end else if (cmd_i.carve) begin
        top_q <= TopW'(BlocksPerChunk - 1);
      end
      if (cmd_i.carve) begin
        chunk_cnt_q <= chunk_cnt_q + CcW'(1);
        base_q      <= base_q + IdxW'(BlocksPerChunk);
        fill_cnt_q  <= '0;
      end else if (cmd_i.fill_step) begin
        fill_cnt_q <= fill_cnt_q + FillW'(1);
      end
    end
  end

  // ---- result word and fill base ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.carve) begin
      fill_base_q <= base_q;
    end
    if (cmd_i.accept) begin
      status_q   <= status_d;
      refilled_q <= cmd_i.carve;
      from_ram_q <= cmd_i.pop;
      granted_q  <= cmd_i.carve ? carve_grant : '0;
    end
  end

  assign done_o          = res_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = from_ram_q ? ram_rdata : granted_q;
  assign refilled_o      = refilled_q;

endmodule

/* rtl/fixed_block_free_list_allocator.sv */
// Top level of the fixed-block free-list allocator: controller + datapath.
// Depends on fbfla_pkg, fbfla_ctrl, fbfla_dp (which holds fbfla_ram).
//
//  Channel   Handshake                 Payload
//  request   start / busy (in)         op_i, request_size_i, align_log2_i,
//                                      is_null_i, block_index_i
//  result    done_o strobe (out)       status_o, granted_block_o, refilled_o
//  config    chunk_limit_we_i (in)     chunk_limit_i
//
// Every request gives one result word on done_o in the cycle after it is
// taken. Push, pop and all error cases leave busy low; a pop reads the
// free stack's RAM, whose registered data drives granted_block_o directly.
// An allocate that carves a chunk returns its top block at once, then holds
// busy high while the remaining blocks are written into the stack RAM one
// per cycle (single write port sets this). Reset empties the stack and
// clears the chunk count; the stack RAM itself is not cleared. The receiver
// has no backpressure: done_o is one cycle.
module fixed_block_free_list_allocator import fbfla_pkg::*; #(
  parameter int BLOCK_SIZE       = BlockSizeDef,       // 16 .. 65536
  parameter int BLOCKS_PER_CHUNK = BlocksPerChunkDef,  // 1 .. 256
  parameter int MAX_CHUNKS       = MaxChunksDef        // 1 .. 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              chunk_limit_we_i,
  input  logic [LimitW-1:0] chunk_limit_i,
  // request word
  input  logic              start,
  output logic              busy,
  input  logic              op_i,
  input  logic [SizeW-1:0]  request_size_i,
  input  logic [AlignW-1:0] align_log2_i,
  input  logic              is_null_i,
  input  logic [IdxW-1:0]   block_index_i,
  // result word
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [IdxW-1:0]   granted_block_o,
  output logic              refilled_o
);

  fbfla_cmd_t  cmd;
  fbfla_stat_t stat;

  // Sequencer: idle accepts requests, fill walks a freshly carved chunk.
  fbfla_ctrl #(
    .BlocksPerChunk (BLOCKS_PER_CHUNK)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Stack pointer, chunk bookkeeping, classification and result registers.
  fbfla_dp #(
    .BlockSize      (BLOCK_SIZE),
    .BlocksPerChunk (BLOCKS_PER_CHUNK),
    .MaxChunks      (MAX_CHUNKS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .chunk_limit_we_i (chunk_limit_we_i),
    .chunk_limit_i    (chunk_limit_i),
    .op_i             (op_i),
    .request_size_i   (request_size_i),
    .align_log2_i     (align_log2_i),
    .is_null_i        (is_null_i),
    .block_index_i    (block_index_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_block_o  (granted_block_o),
    .refilled_o       (refilled_o)
  );

endmodule

/* rtl/fbfla_checker.sv */
// Port-level checker for the allocator, bound to the top level.
// Depends on fbfla_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbfla_checker import fbfla_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic [2:0]      status_o,
  input logic [IdxW-1:0] granted_block_o,
  input logic            refilled_o
);

  // every accepted request answers in the next cycle
  `ASSERT_NEXT(a_resp_next, clk_i, rst_ni, start && !busy, done_o)
  // no unsolicited result word
  `ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, done_o, $past(start && !busy))
  // failures grant nothing
  `ASSERT_IMPLY(a_fail_no_grant, clk_i, rst_ni, done_o && (status_o != STS_OK),
                (granted_block_o == '0) && !refilled_o)
  // status codes stay in range
  `ASSERT_IMPLY(a_status_range, clk_i, rst_ni, done_o, status_o <= STS_OVERFLOW)

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .granted_block_o (granted_block_o),
  .refilled_o      (refilled_o)
);
